FILE: rtl/uart16550_pkg.sv
// Shared types, codes and helpers for the 16550 register block.
`default_nettype none

package uart16550_pkg;

    localparam int FIFO_DEPTH_DEF = 16;

    // Request opcodes
    localparam logic [2:0] OP_BUS_READ  = 3'd0;
    localparam logic [2:0] OP_BUS_WRITE = 3'd1;
    localparam logic [2:0] OP_RX_BYTE   = 3'd2;
    localparam logic [2:0] OP_TX_SLOT   = 3'd3;
    localparam logic [2:0] OP_MODEM     = 3'd4;

    // Register offsets
    localparam logic [2:0] REG_RHR_THR = 3'd0;
    localparam logic [2:0] REG_IER     = 3'd1;
    localparam logic [2:0] REG_IIR_FCR = 3'd2;
    localparam logic [2:0] REG_LCR     = 3'd3;
    localparam logic [2:0] REG_MCR     = 3'd4;
    localparam logic [2:0] REG_LSR     = 3'd5;
    localparam logic [2:0] REG_MSR     = 3'd6;
    localparam logic [2:0] REG_SCR     = 3'd7;

    // Interrupt identification codes
    localparam logic [7:0] IIR_NONE   = 8'h01;
    localparam logic [7:0] IIR_LINE   = 8'h06;
    localparam logic [7:0] IIR_RXDATA = 8'h04;
    localparam logic [7:0] IIR_THRE   = 8'h02;
    localparam logic [7:0] IIR_MODEM  = 8'h00;
    localparam logic [7:0] IIR_FIFO_BITS = 8'hC0;

    localparam logic [3:0] MSR_DELTA_LEVEL = 4'b1011;
    localparam logic [3:0] MSR_TERI        = 4'b0100;
    localparam logic [7:0] LSR_TX_EMPTY    = 8'h60;

    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] reg_address;
        logic [7:0] write_data;
        logic [7:0] line_byte;
        logic [3:0] modem_lines;
    } in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq;
        logic [4:0] out_lines;
    } out_t;

    // Per-request info carried from the control stage to the result stage
    typedef struct packed {
        logic       rx_pop;
        logic       tx_pop;
        logic [7:0] read_data;
        logic       irq;
        logic [4:0] out_lines;
    } stage_t;

    function automatic logic [7:0] irq_id(input logic [3:0] ier, input logic overrun,
                                          input logic rx_any, input logic thre,
                                          input logic [3:0] deltas);
        logic [7:0] id;
        begin
            if (ier[2] && overrun) begin
                id = IIR_LINE;
            end else if (ier[0] && rx_any) begin
                id = IIR_RXDATA;
            end else if (ier[1] && thre) begin
                id = IIR_THRE;
            end else if (ier[3] && (deltas != 4'd0)) begin
                id = IIR_MODEM;
            end else begin
                id = IIR_NONE;
            end
            return id;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/uart16550_ram.sv
// Simple dual-port FIFO storage, one write and one registered read per cycle.
`default_nettype none

module uart16550_ram #(
    parameter int DEPTH = uart16550_pkg::FIFO_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/uart16550_ctrl.sv
// Register file, FIFO pointers and request decode for the 16550 block.
`default_nettype none

module uart16550_ctrl #(
    parameter int DEPTH = uart16550_pkg::FIFO_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 accept,
    input  wire uart16550_pkg::in_t   req,
    output logic                      rx_wr_en,
    output logic      [AW-1:0]        rx_wr_addr,
    output logic                      rx_rd_en,
    output logic      [AW-1:0]        rx_rd_addr,
    output logic                      tx_wr_en,
    output logic      [AW-1:0]        tx_wr_addr,
    output logic                      tx_rd_en,
    output logic      [AW-1:0]        tx_rd_addr,
    output uart16550_pkg::stage_t     info
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0] rx_head_reg, rx_head_next, tx_head_reg, tx_head_next;
    logic [CW-1:0] rx_count_reg, rx_count_next, tx_count_reg, tx_count_next;
    logic [3:0]    ier_reg, ier_next;
    logic [7:0]    lcr_reg, lcr_next;
    logic [4:0]    mcr_reg, mcr_next;
    logic [15:0]   div_reg, div_next;
    logic [7:0]    scr_reg, scr_next;
    logic          fifo_on_reg, fifo_on_next;
    logic          overrun_reg, overrun_next;
    logic          thre_reg, thre_next;
    logic [3:0]    levels_reg, levels_next;
    logic [3:0]    deltas_reg, deltas_next;

    logic [CW-1:0] cap;
    logic          dlab;
    logic [7:0]    cur_id;
    logic [7:0]    rd_val;
    logic          rx_pop, tx_pop, rx_push, tx_push;
    logic [SW-1:0] rx_sum, tx_sum;
    logic [3:0]    changed;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        begin
            if (p == AW'(DEPTH - 1)) begin
                r = '0;
            end else begin
                r = p + AW'(1);
            end
            return r;
        end
    endfunction

    assign cap    = fifo_on_reg ? CW'(DEPTH) : CW'(1);
    assign dlab   = lcr_reg[7];
    assign cur_id = uart16550_pkg::irq_id(ier_reg, overrun_reg, rx_count_reg != '0,
                                          thre_reg, deltas_reg);

    // Tail address = (head + count) mod DEPTH, sum stays below 2*DEPTH
    always_comb begin
        rx_sum = SW'(rx_head_reg) + SW'(rx_count_reg);
        if (rx_sum >= SW'(DEPTH)) begin
            rx_sum = rx_sum - SW'(DEPTH);
        end
        tx_sum = SW'(tx_head_reg) + SW'(tx_count_reg);
        if (tx_sum >= SW'(DEPTH)) begin
            tx_sum = tx_sum - SW'(DEPTH);
        end
    end

    always_comb begin
        rx_head_next  = rx_head_reg;
        rx_count_next = rx_count_reg;
        tx_head_next  = tx_head_reg;
        tx_count_next = tx_count_reg;
        ier_next      = ier_reg;
        lcr_next      = lcr_reg;
        mcr_next      = mcr_reg;
        div_next      = div_reg;
        scr_next      = scr_reg;
        fifo_on_next  = fifo_on_reg;
        overrun_next  = overrun_reg;
        thre_next     = thre_reg;
        levels_next   = levels_reg;
        deltas_next   = deltas_reg;
        rd_val        = 8'd0;
        rx_pop        = 1'b0;
        tx_pop        = 1'b0;
        rx_push       = 1'b0;
        tx_push       = 1'b0;
        changed       = levels_reg ^ req.modem_lines;

        unique case (req.opcode)
            uart16550_pkg::OP_BUS_READ: begin
                unique case (req.reg_address)
                    uart16550_pkg::REG_RHR_THR: begin
                        if (dlab) begin
                            rd_val = div_reg[7:0];
                        end else if (rx_count_reg != '0) begin
                            rx_pop        = 1'b1;
                            rx_head_next  = wrap_inc(rx_head_reg);
                            rx_count_next = rx_count_reg - CW'(1);
                        end
                    end
                    uart16550_pkg::REG_IER: begin
                        rd_val = dlab ? div_reg[15:8] : {4'd0, ier_reg};
                    end
                    uart16550_pkg::REG_IIR_FCR: begin
                        if (cur_id == uart16550_pkg::IIR_THRE) begin
                            thre_next = 1'b0;
                        end
                        rd_val = cur_id | (fifo_on_reg ? uart16550_pkg::IIR_FIFO_BITS : 8'd0);
                    end
                    uart16550_pkg::REG_LCR: rd_val = lcr_reg;
                    uart16550_pkg::REG_MCR: rd_val = {3'd0, mcr_reg};
                    uart16550_pkg::REG_LSR: begin
                        rd_val = {6'd0, overrun_reg, rx_count_reg != '0}
                               | ((tx_count_reg == '0) ? uart16550_pkg::LSR_TX_EMPTY : 8'd0);
                        overrun_next = 1'b0;
                    end
                    uart16550_pkg::REG_MSR: begin
                        rd_val      = {levels_reg, deltas_reg};
                        deltas_next = 4'd0;
                    end
                    uart16550_pkg::REG_SCR: rd_val = scr_reg;
                    default: rd_val = 8'd0;
                endcase
            end
            uart16550_pkg::OP_BUS_WRITE: begin
                unique case (req.reg_address)
                    uart16550_pkg::REG_RHR_THR: begin
                        if (dlab) begin
                            div_next[7:0] = req.write_data;
                        end else begin
                            thre_next = 1'b0;
                            if (tx_count_reg < cap) begin
                                tx_push       = 1'b1;
                                tx_count_next = tx_count_reg + CW'(1);
                            end
                        end
                    end
                    uart16550_pkg::REG_IER: begin
                        if (dlab) begin
                            div_next[15:8] = req.write_data;
                        end else begin
                            if (req.write_data[1] && !ier_reg[1] && tx_count_reg == '0) begin
                                thre_next = 1'b1;
                            end
                            ier_next = req.write_data[3:0];
                        end
                    end
                    uart16550_pkg::REG_IIR_FCR: begin
                        // mode change flushes both FIFOs before the clear bits apply
                        if (req.write_data[0] != fifo_on_reg) begin
                            fifo_on_next  = req.write_data[0];
                            rx_head_next  = '0;
                            rx_count_next = '0;
                            tx_head_next  = '0;
                            tx_count_next = '0;
                            thre_next     = 1'b1;
                        end
                        if (req.write_data[1]) begin
                            rx_head_next  = '0;
                            rx_count_next = '0;
                        end
                        if (req.write_data[2]) begin
                            tx_head_next  = '0;
                            tx_count_next = '0;
                            thre_next     = 1'b1;
                        end
                    end
                    uart16550_pkg::REG_LCR: lcr_next = req.write_data;
                    uart16550_pkg::REG_MCR: mcr_next = req.write_data[4:0];
                    uart16550_pkg::REG_SCR: scr_next = req.write_data;
                    default: ;
                endcase
            end
            uart16550_pkg::OP_RX_BYTE: begin
                if (rx_count_reg >= cap) begin
                    overrun_next = 1'b1;
                end else begin
                    rx_push       = 1'b1;
                    rx_count_next = rx_count_reg + CW'(1);
                end
            end
            uart16550_pkg::OP_TX_SLOT: begin
                if (tx_count_reg != '0) begin
                    tx_pop        = 1'b1;
                    tx_head_next  = wrap_inc(tx_head_reg);
                    tx_count_next = tx_count_reg - CW'(1);
                    if (tx_count_reg == CW'(1)) begin
                        thre_next = 1'b1;
                    end
                end
            end
            uart16550_pkg::OP_MODEM: begin
                deltas_next = deltas_reg | (changed & uart16550_pkg::MSR_DELTA_LEVEL);
                if (levels_reg[2] && !req.modem_lines[2]) begin
                    deltas_next = deltas_next | uart16550_pkg::MSR_TERI;
                end
                levels_next = req.modem_lines;
            end
            default: ;
        endcase
    end

    assign rx_wr_en   = accept && rx_push;
    assign rx_wr_addr = rx_sum[AW-1:0];
    assign rx_rd_en   = accept && rx_pop;
    assign rx_rd_addr = rx_head_reg;
    assign tx_wr_en   = accept && tx_push;
    assign tx_wr_addr = tx_sum[AW-1:0];
    assign tx_rd_en   = accept && tx_pop;
    assign tx_rd_addr = tx_head_reg;

    always_comb begin
        info.rx_pop    = rx_pop;
        info.tx_pop    = tx_pop;
        info.read_data = rd_val;
        info.irq       = uart16550_pkg::irq_id(ier_next, overrun_next, rx_count_next != '0,
                                               thre_next, deltas_next)
                         != uart16550_pkg::IIR_NONE;
        info.out_lines = mcr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_head_reg  <= '0;
            rx_count_reg <= '0;
            tx_head_reg  <= '0;
            tx_count_reg <= '0;
            ier_reg      <= '0;
            lcr_reg      <= '0;
            mcr_reg      <= '0;
            div_reg      <= '0;
            scr_reg      <= '0;
            fifo_on_reg  <= 1'b0;
            overrun_reg  <= 1'b0;
            thre_reg     <= 1'b0;
            levels_reg   <= '0;
            deltas_reg   <= '0;
        end else if (accept) begin
            rx_head_reg  <= rx_head_next;
            rx_count_reg <= rx_count_next;
            tx_head_reg  <= tx_head_next;
            tx_count_reg <= tx_count_next;
            ier_reg      <= ier_next;
            lcr_reg      <= lcr_next;
            mcr_reg      <= mcr_next;
            div_reg      <= div_next;
            scr_reg      <= scr_next;
            fifo_on_reg  <= fifo_on_next;
            overrun_reg  <= overrun_next;
            thre_reg     <= thre_next;
            levels_reg   <= levels_next;
            deltas_reg   <= deltas_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/uart_16550_register_model.sv
// Top level of the 16550 register block: control stage, FIFO memories, result stages.
// Throughput: one request per clock; s_ready drops only while both result stages are full
// and m_ready is low.
// Each accepted request is registered in stage 1, then in the output register that drives m_valid.
// Reset (aresetn low, synchronous) clears control registers, pointers and valid flags;
// stage data and FIFO memories are not cleared and hold unknown data until written.
`default_nettype none

module uart_16550_register_model #(
    parameter int FIFO_DEPTH = uart16550_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire uart16550_pkg::in_t  s_payload,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output uart16550_pkg::out_t      m_payload
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    logic          accept;
    logic          rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
    logic [AW-1:0] rx_wr_addr, rx_rd_addr, tx_wr_addr, tx_rd_addr;
    logic [7:0]    rx_dout, tx_dout;

    uart16550_pkg::stage_t info;
    uart16550_pkg::stage_t s1_reg;
    logic                  s1_valid_reg, s1_valid_next;
    uart16550_pkg::out_t   out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  s1_move;

    // Stage 1 takes a new request whenever it is empty or hands its
    // current one to the output register in the same cycle.
    assign s_ready = !s1_valid_reg || !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign s1_move = s1_valid_reg && (!out_valid_reg || m_ready);

    uart16550_ctrl #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .req        (s_payload),
        .rx_wr_en   (rx_wr_en),
        .rx_wr_addr (rx_wr_addr),
        .rx_rd_en   (rx_rd_en),
        .rx_rd_addr (rx_rd_addr),
        .tx_wr_en   (tx_wr_en),
        .tx_wr_addr (tx_wr_addr),
        .tx_rd_en   (tx_rd_en),
        .tx_rd_addr (tx_rd_addr),
        .info       (info)
    );

    // Each request touches at most one port of one FIFO, so no read ever
    // meets a write to the same entry in the same cycle.
    uart16550_ram #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW)
    ) u_rx_ram (
        .aclk    (aclk),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_wr_addr),
        .wr_data (s_payload.line_byte),
        .rd_en   (rx_rd_en),
        .rd_addr (rx_rd_addr),
        .rd_data (rx_dout)
    );

    uart16550_ram #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW)
    ) u_tx_ram (
        .aclk    (aclk),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_wr_addr),
        .wr_data (s_payload.write_data),
        .rd_en   (tx_rd_en),
        .rd_addr (tx_rd_addr),
        .rd_data (tx_dout)
    );

    // Memory outputs hold while stage 1 is stalled: no new pop can be
    // accepted until stage 1 moves on.
    always_comb begin
        out_next.read_data = s1_reg.rx_pop ? rx_dout : s1_reg.read_data;
        out_next.tx_valid  = s1_reg.tx_pop;
        out_next.tx_byte   = s1_reg.tx_pop ? tx_dout : 8'd0;
        out_next.irq       = s1_reg.irq;
        out_next.out_lines = s1_reg.out_lines;
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_move) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= info;
        end
        if (s1_move) begin
            out_reg <= out_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

endmodule

`default_nettype wire
